>>> rtl/core/tscbp_pkg.sv
package tscbp_pkg;

	// Default sizing
	localparam int NUM_TABLES_DEF       = 8;
	localparam int TAGGED_DEPTH_DEF     = 1024;
	localparam int BASE_DEPTH_DEF       = 2048;
	localparam int CORRECTOR_DEPTH_DEF  = 1024;
	localparam int CORRECTOR_TABLES_DEF = 5;
	localparam int HISTORY_BITS_DEF     = 128;

	// Fixed field widths and constants
	localparam int MAX_HIST  = 128;
	localparam int TAG_BITS  = 8;
	localparam int CTR_W     = 3;
	localparam int U_W       = 2;
	localparam int SC_W      = 6;
	localparam int PROV_W    = 3;
	localparam int SKIP_W    = 6;
	localparam int PERIOD_W  = 21;
	localparam int THR_W     = 8;
	localparam int TC_W      = 7;
	localparam int ALT_W     = 4;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 21'd131072;
	localparam logic [1:0]          BASE_INIT    = 2'd2;
	localparam logic [CTR_W-1:0]    CTR_MAX      = 3'd7;
	localparam logic [CTR_W-1:0]    CTR_NEW      = 3'd4;
	localparam logic [CTR_W-1:0]    CTR_WEAK_NT  = 3'd3;
	localparam logic [U_W-1:0]      U_MAX        = 2'd3;
	localparam logic [SC_W-1:0]     SC_MAX       = 6'd63;
	localparam logic [SC_W-1:0]     SC_MID       = 6'd32;
	localparam logic [THR_W-1:0]    THR_RESET    = 8'd5;
	localparam logic [THR_W-1:0]    THR_MAX      = 8'd255;
	localparam logic [TC_W-1:0]     TC_MAX       = 7'd127;
	localparam logic [TC_W-1:0]     TC_MID       = 7'd64;
	localparam logic [ALT_W-1:0]    ALT_MAX      = 4'd15;
	localparam logic [ALT_W-1:0]    ALT_MID      = 4'd8;

	// Controller to datapath commands
	typedef struct packed {
		logic ld;       // input word accepted
		logic pred;     // table read data valid, resolve provider
		logic sum;      // corrector read data valid, form sum
		logic upd;      // write back and emit result
		logic init_we;  // reset fill of all tables
		logic uclr_we;  // useful bit clearing walk
	} dp_cmd_t;

	function automatic logic [31:0] low_mask(input int w);
		logic [32:0] m;
		m = (33'd1 << w) - 33'd1;
		return m[31:0];
	endfunction

	// Folded history length of table e, capped by the history size
	function automatic int hist_len(input int e, input int hb);
		int l;
		l = (e < 8) ? (1 << e) : MAX_HIST;
		return (l > hb) ? hb : l;
	endfunction

	// XOR the low len history bits into w-bit chunks
	function automatic logic [31:0] fold_hist(input logic [MAX_HIST-1:0] h, input int len,
		input int w);
		logic [31:0] acc;
		int j;
		acc = '0;
		j = 0;
		for (int i = 0; i < MAX_HIST; i++) begin
			if (i < len) acc[j] = acc[j] ^ h[i];
			j = (j == w - 1) ? 0 : j + 1;
		end
		return acc & low_mask(w);
	endfunction

	function automatic logic [31:0] fold_pc(input logic [31:0] pc, input int w);
		logic [31:0] acc;
		int j;
		acc = '0;
		j = 0;
		for (int i = 0; i < 32; i++) begin
			acc[j] = acc[j] ^ pc[i];
			j = (j == w - 1) ? 0 : j + 1;
		end
		return acc & low_mask(w);
	endfunction

	function automatic logic [31:0] hash_idx(input logic [31:0] pc,
		input logic [MAX_HIST-1:0] h, input int len, input int w);
		return (fold_pc(pc, w) ^ fold_hist(h, len, w)) & low_mask(w);
	endfunction

	function automatic logic [31:0] hash_tag(input logic [31:0] pc,
		input logic [MAX_HIST-1:0] h, input int len, input int w);
		return (fold_pc(pc, w) ^ fold_hist(h, len, w) ^ (fold_hist(h, len, w - 1) << 1))
			& low_mask(w);
	endfunction

endpackage

>>> rtl/core/tscbp_ram.sv
module tscbp_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/tscbp_ctrl.sv
module tscbp_ctrl import tscbp_pkg::*; #(
	parameter int TAGGED_DEPTH = TAGGED_DEPTH_DEF,
	parameter int MAX_DEPTH    = BASE_DEPTH_DEF,
	parameter int WALK_W       = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  logic              clr_due,
	output dp_cmd_t           cmd,
	output logic [WALK_W-1:0] walk_addr
);

	typedef enum logic [2:0] {
		ST_INIT, ST_IDLE, ST_PRED, ST_SCRD, ST_SUM, ST_UPD, ST_UCLR
	} state_t;

	state_t            state_q;
	logic [WALK_W-1:0] walk_q;
	logic              out_valid_q;
	logic              accept;
	logic              upd_go;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign upd_go    = (state_q == ST_UPD) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign walk_addr = walk_q;

	// command decode
	always_comb begin
		cmd         = '0;
		cmd.ld      = accept;
		cmd.pred    = (state_q == ST_PRED);
		cmd.sum     = (state_q == ST_SUM);
		cmd.upd     = upd_go;
		cmd.init_we = (state_q == ST_INIT);
		cmd.uclr_we = (state_q == ST_UCLR);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			walk_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (upd_go) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;

			case (state_q)
				ST_INIT: begin
					walk_q <= walk_q + 1'b1;
					if (walk_q == WALK_W'(MAX_DEPTH - 1)) begin
						walk_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) state_q <= ST_PRED;
				end
				ST_PRED: state_q <= ST_SCRD;
				ST_SCRD: state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_UPD;
				ST_UPD: begin
					if (upd_go) begin
						walk_q  <= '0;
						state_q <= clr_due ? ST_UCLR : ST_IDLE;
					end
				end
				ST_UCLR: begin
					walk_q <= walk_q + 1'b1;
					if (walk_q == WALK_W'(TAGGED_DEPTH - 1)) begin
						walk_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_INIT;
			endcase
		end
	end

endmodule

>>> rtl/core/tscbp_dp.sv
module tscbp_dp import tscbp_pkg::*; #(
	parameter int NUM_TABLES       = NUM_TABLES_DEF,
	parameter int TAGGED_DEPTH     = TAGGED_DEPTH_DEF,
	parameter int BASE_DEPTH       = BASE_DEPTH_DEF,
	parameter int CORRECTOR_DEPTH  = CORRECTOR_DEPTH_DEF,
	parameter int CORRECTOR_TABLES = CORRECTOR_TABLES_DEF,
	parameter int HISTORY_BITS     = HISTORY_BITS_DEF,
	parameter int WALK_W           = 11
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	input  logic [WALK_W-1:0]   walk_addr,
	input  logic                cfg_write_en,
	input  logic [PERIOD_W-1:0] cfg_write_data,
	input  logic [31:0]         branch_pc,
	input  logic                taken,
	input  logic [SKIP_W-1:0]   alloc_skip,
	output logic                clr_due,
	output logic                predicted_taken,
	output logic [PROV_W-1:0]   provider_table,
	output logic                used_alternate
);

	localparam int NTT = NUM_TABLES - 1;
	localparam int GW  = $clog2(TAGGED_DEPTH);
	localparam int BW  = $clog2(BASE_DEPTH);
	localparam int CW  = $clog2(CORRECTOR_DEPTH);
	localparam int CTW = CTR_W + TAG_BITS;
	localparam logic signed [10:0] CT_S = 11'(CORRECTOR_TABLES);

	// global state
	logic [HISTORY_BITS-1:0] hist_q;
	logic [MAX_HIST-1:0]     hist_ext;
	logic [PERIOD_W-1:0]     period_q;
	logic [PERIOD_W-1:0]     bc_q;
	logic                    sel_q;
	logic                    clr_bit_q;
	logic                    clr_q;
	logic [ALT_W-1:0]        alt_bias_q;
	logic [THR_W-1:0]        thr_q;
	logic [TC_W-1:0]         tc_q;

	// accepted word
	logic                    tk_q;
	logic [SKIP_W-1:0]       skip_q;
	logic [BW-1:0]           bidx_c, bidx_q;
	logic [GW-1:0]           idx_c [NTT];
	logic [GW-1:0]           idx_q [NTT];
	logic [TAG_BITS-1:0]     tag_c [NTT];
	logic [TAG_BITS-1:0]     tag_q [NTT];
	logic [CW-1:0]           sch_c [CORRECTOR_TABLES];
	logic [CW-1:0]           sch_q [CORRECTOR_TABLES];
	logic [CW-1:0]           cidx_q [CORRECTOR_TABLES];

	// table read data
	logic [CTR_W-1:0]        rd_ctr [NTT];
	logic [TAG_BITS-1:0]     rd_tag [NTT];
	logic [U_W-1:0]          rd_u [NTT];
	logic [1:0]              rd_bctr;
	logic [SC_W-1:0]         sc_rd [CORRECTOR_TABLES];

	// resolved prediction
	logic [CTR_W-1:0]        ent_ctr_q [NTT];
	logic [TAG_BITS-1:0]     ent_tag_q [NTT];
	logic [U_W-1:0]          ent_u_q [NTT];
	logic [1:0]              bctr_q;
	logic [PROV_W-1:0]       prov_q, src_q;
	logic                    pred_bit_q, alt_bit_q, fresh_q, use_alt_q;
	logic [CTR_W-1:0]        pctr_q;
	logic                    final_q;
	logic [9:0]              mag_q;

	// write back data
	logic [CTR_W-1:0]        wr_ctr [NTT];
	logic [TAG_BITS-1:0]     wr_tag [NTT];
	logic [U_W-1:0]          wr_u [NTT];
	logic [SC_W-1:0]         sc_wr [CORRECTOR_TABLES];
	logic [1:0]              bctr_wr;

	assign hist_ext = MAX_HIST'(hist_q);
	assign bidx_c   = branch_pc[BW-1:0];
	assign clr_due  = clr_q;

	// provider and alternate lookup
	logic [PROV_W-1:0] prov_c, alt_c, src_c;
	logic [CTR_W-1:0]  p_ctr, a_ctr, pctr_c;
	logic [U_W-1:0]    p_u;
	logic              pred_bit_c, alt_bit_c, fresh_c, use_alt_c;

	always_comb begin
		prov_c = '0;
		alt_c  = '0;
		p_ctr  = '0;
		a_ctr  = '0;
		p_u    = '0;
		for (int i = 0; i < NTT; i++) begin
			if (rd_tag[i] == tag_q[i]) begin
				alt_c  = prov_c;
				prov_c = PROV_W'(i + 1);
			end
		end
		for (int i = 0; i < NTT; i++) begin
			if (PROV_W'(i + 1) == prov_c) begin
				p_ctr = rd_ctr[i];
				p_u   = rd_u[i];
			end
			if (PROV_W'(i + 1) == alt_c) a_ctr = rd_ctr[i];
		end
		pred_bit_c = (prov_c != '0) ? p_ctr[2] : rd_bctr[1];
		alt_bit_c  = (alt_c != '0) ? a_ctr[2] : rd_bctr[1];
		fresh_c    = (prov_c != '0) && (p_u == '0) &&
			((p_ctr == CTR_WEAK_NT) || (p_ctr == CTR_NEW));
		use_alt_c  = fresh_c && (alt_bias_q >= ALT_MID);
		src_c      = use_alt_c ? alt_c : prov_c;
		pctr_c     = (src_c != '0) ? (use_alt_c ? a_ctr : p_ctr) : {1'b0, rd_bctr};
	end

	// corrector sum
	logic signed [10:0] sum_c, tv_c, val_c;
	logic [9:0]         mag_c;

	always_comb begin
		sum_c = '0;
		for (int k = 0; k < CORRECTOR_TABLES; k++)
			sum_c = sum_c + $signed({4'b0, sc_rd[k], 1'b0}) - 11'sd63;
		tv_c  = $signed({7'b0, pctr_q, 1'b0}) - ((src_q != '0) ? 11'sd7 : 11'sd3);
		val_c = sum_c + tv_c * CT_S;
		mag_c = sum_c[10] ? 10'(-sum_c) : 10'(sum_c);
	end

	// tagged table update and allocation
	logic             mis, alloc_en, done;
	logic [U_W-1:0]   mu [NTT];
	logic [NTT-1:0]   free_v, chosen, cand_v;
	logic [2:0]       nfree, rank;
	logic [SKIP_W:0]  skip_ext;
	logic [U_W-1:0]   uu;

	always_comb begin
		mis      = pred_bit_q ^ tk_q;
		alloc_en = mis && (prov_q != PROV_W'(NTT));
		skip_ext = {1'b0, skip_q};
		nfree    = '0;
		rank     = '0;
		done     = 1'b0;
		chosen   = '0;
		uu       = '0;
		for (int i = 0; i < NTT; i++) begin
			mu[i] = ent_u_q[i];
			if (clr_q) mu[i][sel_q] = 1'b0;
			cand_v[i] = alloc_en && (PROV_W'(i + 1) > prov_q);
			free_v[i] = cand_v[i] && (mu[i] == '0);
			nfree     = nfree + 3'(free_v[i]);
		end
		for (int i = 0; i < NTT; i++) begin
			if (free_v[i] && !done) begin
				if ((rank + 3'd1 == nfree) || (rank >= 3'(SKIP_W)) || !skip_ext[rank]) begin
					chosen[i] = 1'b1;
					done      = 1'b1;
				end
				rank = rank + 3'd1;
			end
		end
		for (int i = 0; i < NTT; i++) begin
			wr_ctr[i] = ent_ctr_q[i];
			wr_tag[i] = ent_tag_q[i];
			wr_u[i]   = mu[i];
			if (PROV_W'(i + 1) == prov_q) begin
				wr_ctr[i] = tk_q ? ((ent_ctr_q[i] == CTR_MAX) ? CTR_MAX : ent_ctr_q[i] + 1'b1)
					: ((ent_ctr_q[i] == '0) ? '0 : ent_ctr_q[i] - 1'b1);
				uu = ent_u_q[i];
				if (pred_bit_q != alt_bit_q)
					uu = (pred_bit_q == tk_q) ? ((uu == U_MAX) ? U_MAX : uu + 1'b1)
						: ((uu == '0) ? '0 : uu - 1'b1);
				if (clr_q) uu[sel_q] = 1'b0;
				wr_u[i] = uu;
			end else if (chosen[i]) begin
				wr_ctr[i] = CTR_NEW;
				wr_tag[i] = tag_q[i];
				wr_u[i]   = '0;
			end else if (cand_v[i] && (nfree == '0)) begin
				wr_u[i] = (mu[i] == '0) ? '0 : mu[i] - 1'b1;
			end
		end
	end

	// base and corrector write data
	logic sc_train;

	always_comb begin
		bctr_wr  = tk_q ? ((bctr_q == 2'd3) ? 2'd3 : bctr_q + 1'b1)
			: ((bctr_q == 2'd0) ? 2'd0 : bctr_q - 1'b1);
		sc_train = (final_q != tk_q) || (mag_q < {2'b0, thr_q});
		for (int k = 0; k < CORRECTOR_TABLES; k++) begin
			sc_wr[k] = sc_rd[k];
			if (sc_train)
				sc_wr[k] = tk_q ? ((sc_rd[k] == SC_MAX) ? SC_MAX : sc_rd[k] + 1'b1)
					: ((sc_rd[k] == '0) ? '0 : sc_rd[k] - 1'b1);
		end
	end

	// base table
	logic          base_init;
	assign base_init = cmd.init_we && ((walk_addr >> BW) == '0);

	tscbp_ram #(.WIDTH(2), .DEPTH(BASE_DEPTH)) u_base (
		.clk   (clk),
		.we    (base_init || cmd.upd),
		.waddr (cmd.init_we ? walk_addr[BW-1:0] : bidx_q),
		.wdata (cmd.init_we ? BASE_INIT : bctr_wr),
		.raddr (bidx_c),
		.rdata (rd_bctr)
	);

	// tagged tables: counter and tag, two useful bit planes
	logic tag_walk;
	assign tag_walk = (cmd.init_we || cmd.uclr_we) && ((walk_addr >> GW) == '0);

	for (genvar gi = 0; gi < NTT; gi++) begin : g_tag
		logic [31:0]     hi, ht;
		logic [CTW-1:0]  ct_rd;
		logic [GW-1:0]   waddr;

		assign hi         = hash_idx(branch_pc, hist_ext, hist_len(gi + 1, HISTORY_BITS), GW);
		assign ht         = hash_tag(branch_pc, hist_ext, hist_len(gi + 1, HISTORY_BITS),
			TAG_BITS);
		assign idx_c[gi]  = hi[GW-1:0];
		assign tag_c[gi]  = ht[TAG_BITS-1:0];
		assign rd_ctr[gi] = ct_rd[CTW-1:TAG_BITS];
		assign rd_tag[gi] = ct_rd[TAG_BITS-1:0];
		assign waddr      = (cmd.init_we || cmd.uclr_we) ? walk_addr[GW-1:0] : idx_q[gi];

		tscbp_ram #(.WIDTH(CTW), .DEPTH(TAGGED_DEPTH)) u_ct (
			.clk   (clk),
			.we    ((tag_walk && cmd.init_we) || cmd.upd),
			.waddr (waddr),
			.wdata (cmd.init_we ? '0 : {wr_ctr[gi], wr_tag[gi]}),
			.raddr (idx_c[gi]),
			.rdata (ct_rd)
		);

		tscbp_ram #(.WIDTH(1), .DEPTH(TAGGED_DEPTH)) u_u0 (
			.clk   (clk),
			.we    ((tag_walk && (cmd.init_we || !clr_bit_q)) || cmd.upd),
			.waddr (waddr),
			.wdata (cmd.upd ? wr_u[gi][0] : 1'b0),
			.raddr (idx_c[gi]),
			.rdata (rd_u[gi][0])
		);

		tscbp_ram #(.WIDTH(1), .DEPTH(TAGGED_DEPTH)) u_u1 (
			.clk   (clk),
			.we    ((tag_walk && (cmd.init_we || clr_bit_q)) || cmd.upd),
			.waddr (waddr),
			.wdata (cmd.upd ? wr_u[gi][1] : 1'b0),
			.raddr (idx_c[gi]),
			.rdata (rd_u[gi][1])
		);
	end

	// corrector tables
	logic sc_init;
	assign sc_init = cmd.init_we && ((walk_addr >> CW) == '0);

	for (genvar gk = 0; gk < CORRECTOR_TABLES; gk++) begin : g_sc
		logic [31:0] hs;

		assign hs        = hash_tag(branch_pc, hist_ext, hist_len(gk + 1, HISTORY_BITS), CW);
		assign sch_c[gk] = hs[CW-1:0];

		tscbp_ram #(.WIDTH(SC_W), .DEPTH(CORRECTOR_DEPTH)) u_sc (
			.clk   (clk),
			.we    (sc_init || cmd.upd),
			.waddr (cmd.init_we ? walk_addr[CW-1:0] : cidx_q[gk]),
			.wdata (cmd.init_we ? SC_MID : sc_wr[gk]),
			.raddr (cidx_q[gk]),
			.rdata (sc_rd[gk])
		);
	end

	// per word pipeline registers
	always_ff @(posedge clk) begin
		if (cmd.ld) begin
			tk_q   <= taken;
			skip_q <= alloc_skip;
			bidx_q <= bidx_c;
			for (int i = 0; i < NTT; i++) begin
				idx_q[i] <= idx_c[i];
				tag_q[i] <= tag_c[i];
			end
			for (int k = 0; k < CORRECTOR_TABLES; k++) sch_q[k] <= sch_c[k];
		end
		if (cmd.pred) begin
			for (int i = 0; i < NTT; i++) begin
				ent_ctr_q[i] <= rd_ctr[i];
				ent_tag_q[i] <= rd_tag[i];
				ent_u_q[i]   <= rd_u[i];
			end
			bctr_q     <= rd_bctr;
			prov_q     <= prov_c;
			src_q      <= src_c;
			pred_bit_q <= pred_bit_c;
			alt_bit_q  <= alt_bit_c;
			fresh_q    <= fresh_c;
			use_alt_q  <= use_alt_c;
			pctr_q     <= pctr_c;
			for (int k = 0; k < CORRECTOR_TABLES; k++)
				cidx_q[k] <= sch_q[k] ^ CW'(pctr_c);
		end
		if (cmd.sum) begin
			final_q <= !val_c[10];
			mag_q   <= mag_c;
		end
		if (cmd.upd) begin
			predicted_taken <= final_q;
			provider_table  <= src_q;
			used_alternate  <= use_alt_q;
		end
	end

	// global predictor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q     <= '0;
			period_q   <= PERIOD_RESET;
			bc_q       <= '0;
			sel_q      <= 1'b1;
			clr_bit_q  <= 1'b0;
			clr_q      <= 1'b0;
			alt_bias_q <= ALT_MID;
			thr_q      <= THR_RESET;
			tc_q       <= TC_MID;
		end else begin
			if (cfg_write_en) period_q <= cfg_write_data;
			if (cmd.sum) clr_q <= (PERIOD_W'(bc_q + 1'b1) == period_q);
			if (cmd.upd) begin
				hist_q <= {hist_q[HISTORY_BITS-2:0], tk_q};
				if (clr_q) begin
					bc_q      <= '0;
					clr_bit_q <= sel_q;
					sel_q     <= ~sel_q;
				end else begin
					bc_q <= bc_q + 1'b1;
				end
				// alternate-on-new bias
				if (fresh_q && (pred_bit_q != alt_bit_q))
					alt_bias_q <= (alt_bit_q == tk_q)
						? ((alt_bias_q == ALT_MAX) ? ALT_MAX : alt_bias_q + 1'b1)
						: ((alt_bias_q == '0) ? '0 : alt_bias_q - 1'b1);
				// adaptive corrector threshold
				if (final_q != tk_q) begin
					if (tc_q >= TC_MAX - 1'b1) begin
						if (thr_q != THR_MAX) thr_q <= thr_q + 1'b1;
						tc_q <= TC_MID;
					end else begin
						tc_q <= tc_q + 1'b1;
					end
				end else if (mag_q < {2'b0, thr_q}) begin
					if (tc_q <= 7'd1) begin
						if (thr_q != '0) thr_q <= thr_q - 1'b1;
						tc_q <= TC_MID;
					end else begin
						tc_q <= tc_q - 1'b1;
					end
				end
			end
		end
	end

endmodule

>>> rtl/core/tage_sc_branch_predictor.sv
// Conditional branch direction predictor: bimodal base, tagged tables with
// geometric history, and a statistical corrector on top.
// Input channel: one word per branch (branch_pc, taken, alloc_skip), taken on
// a clock edge with in_valid high and in_stall low. The word is predicted from
// the current tables, then every table is trained with the resolved direction.
// Output channel: one word per branch (predicted_taken, provider_table,
// used_alternate), taken on an edge with out_valid high and out_stall low.
// A word passes through the states PRED, SCRD, SUM and UPD; the result is
// registered at the write back, and no new branch is accepted before it. This is
// set by the dependent tagged and corrector reads and the write back, one port each.
// A held result in the output register does not block the next branch; only
// the write back waits while out_stall holds an earlier result.
// Every useful_reset_period branches a walk over all TAGGED_DEPTH entries clears one
// useful bit plane; no branch is accepted meanwhile.
// Reset: after arst_n releases, a fill pass of max(BASE_DEPTH, TAGGED_DEPTH,
// CORRECTOR_DEPTH) cycles loads reset values; in_stall stays high until then.
// The period register may be written at any time through cfg_write_en.
module tage_sc_branch_predictor import tscbp_pkg::*; #(
	parameter int NUM_TABLES       = NUM_TABLES_DEF,
	parameter int TAGGED_DEPTH     = TAGGED_DEPTH_DEF,
	parameter int BASE_DEPTH       = BASE_DEPTH_DEF,
	parameter int CORRECTOR_DEPTH  = CORRECTOR_DEPTH_DEF,
	parameter int CORRECTOR_TABLES = CORRECTOR_TABLES_DEF,
	parameter int HISTORY_BITS     = HISTORY_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write_en,
	input  logic [PERIOD_W-1:0] cfg_write_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [31:0]         branch_pc,
	input  logic                taken,
	input  logic [SKIP_W-1:0]   alloc_skip,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                predicted_taken,
	output logic [PROV_W-1:0]   provider_table,
	output logic                used_alternate
);

	localparam int MAX_BT = (BASE_DEPTH > TAGGED_DEPTH) ? BASE_DEPTH : TAGGED_DEPTH;
	localparam int MAX_DEPTH = (MAX_BT > CORRECTOR_DEPTH) ? MAX_BT : CORRECTOR_DEPTH;
	localparam int WALK_W = $clog2(MAX_DEPTH);

	dp_cmd_t           cmd;
	logic [WALK_W-1:0] walk_addr;
	logic              clr_due;

	tscbp_ctrl #(
		.TAGGED_DEPTH (TAGGED_DEPTH),
		.MAX_DEPTH    (MAX_DEPTH),
		.WALK_W       (WALK_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.clr_due   (clr_due),
		.cmd       (cmd),
		.walk_addr (walk_addr)
	);

	tscbp_dp #(
		.NUM_TABLES       (NUM_TABLES),
		.TAGGED_DEPTH     (TAGGED_DEPTH),
		.BASE_DEPTH       (BASE_DEPTH),
		.CORRECTOR_DEPTH  (CORRECTOR_DEPTH),
		.CORRECTOR_TABLES (CORRECTOR_TABLES),
		.HISTORY_BITS     (HISTORY_BITS),
		.WALK_W           (WALK_W)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.walk_addr       (walk_addr),
		.cfg_write_en    (cfg_write_en),
		.cfg_write_data  (cfg_write_data),
		.branch_pc       (branch_pc),
		.taken           (taken),
		.alloc_skip      (alloc_skip),
		.clr_due         (clr_due),
		.predicted_taken (predicted_taken),
		.provider_table  (provider_table),
		.used_alternate  (used_alternate)
	);

endmodule

>>> tb/tage_sc_branch_predictor_checker.sv
`timescale 1ns / 100ps

module tage_sc_branch_predictor_checker import tscbp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write_en,
	input  logic [PERIOD_W-1:0] cfg_write_data,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [31:0]         branch_pc,
	input  logic                taken,
	input  logic [SKIP_W-1:0]   alloc_skip,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic                predicted_taken,
	input  logic [PROV_W-1:0]   provider_table,
	input  logic                used_alternate,
	output int                  fail_count,
	output int                  words_pending
);

	localparam int NT  = NUM_TABLES_DEF;
	localparam int TD  = TAGGED_DEPTH_DEF;
	localparam int BD  = BASE_DEPTH_DEF;
	localparam int CD  = CORRECTOR_DEPTH_DEF;
	localparam int CT  = CORRECTOR_TABLES_DEF;
	localparam int TIW = $clog2(TD);
	localparam int BIW = $clog2(BD);
	localparam int CIW = $clog2(CD);

	typedef struct packed {
		logic              pred;
		logic [PROV_W-1:0] prov;
		logic              alt;
	} verdict_t;

	// mirrored predictor state
	logic [MAX_HIST-1:0] ghist;
	logic [1:0]          bim [BD];
	logic [CTR_W-1:0]    t_ctr [1:NT-1][TD];
	logic [TAG_BITS-1:0] t_tag [1:NT-1][TD];
	logic [U_W-1:0]      t_u   [1:NT-1][TD];
	logic [SC_W-1:0]     sc    [CT][CD];
	logic [ALT_W-1:0]    alt_bias;
	logic [PERIOD_W-1:0] br_count;
	logic                u_plane;
	logic [THR_W-1:0]    sc_thr;
	logic [TC_W-1:0]     thr_ctr;
	logic [PERIOD_W-1:0] clear_period;

	verdict_t expected_q[$];

	assign words_pending = expected_q.size();

	// XOR the low len bits of v into w-bit chunks
	function automatic int unsigned fold_bits(logic [MAX_HIST-1:0] v, int len, int w);
		logic [31:0] acc;
		acc = '0;
		for (int i = 0; i < len && i < MAX_HIST; i++)
			acc[i % w] ^= v[i];
		return acc;
	endfunction

	function automatic int geo_len(int e);
		return (e < 8) ? (1 << e) : MAX_HIST;
	endfunction

	function automatic int unsigned mix_index(logic [31:0] pc, int len, int w);
		return fold_bits({96'b0, pc}, 32, w) ^ fold_bits(ghist, len, w);
	endfunction

	function automatic int unsigned mix_tag(logic [31:0] pc, int len, int w);
		int unsigned v;
		v = mix_index(pc, len, w) ^ (fold_bits(ghist, len, w - 1) << 1);
		return v & ((1 << w) - 1);
	endfunction

	task automatic clear_state();
		ghist = '0;
		foreach (bim[i]) bim[i] = BASE_INIT;
		for (int t = 1; t < NT; t++)
			for (int i = 0; i < TD; i++) begin
				t_ctr[t][i] = '0;
				t_tag[t][i] = '0;
				t_u[t][i] = '0;
			end
		for (int k = 0; k < CT; k++)
			for (int i = 0; i < CD; i++) sc[k][i] = SC_MID;
		alt_bias = ALT_MID;
		br_count = '0;
		u_plane = 1'b1;
		sc_thr = THR_RESET;
		thr_ctr = TC_MID;
		clear_period = PERIOD_RESET;
	endtask

	// predict one branch, then train on its outcome
	task automatic predict_and_train(input logic [31:0] pc, input logic tk,
		input logic [SKIP_W-1:0] skip, output verdict_t v);
		int unsigned idx[NT], tg[NT], cidx[CT], cand[NT];
		int prov, alt, src, nfree, sum, val, mag, bidx;
		logic pred_bit, alt_bit, use_alt, fin;
		logic [CTR_W-1:0] pctr;
		logic [1:0] bctr;
		prov = 0;
		alt = 0;
		sum = 0;
		nfree = 0;
		bidx = pc[BIW-1:0];
		bctr = bim[bidx];
		for (int t = 1; t < NT; t++) begin
			idx[t] = mix_index(pc, geo_len(t), TIW) & (TD - 1);
			tg[t] = mix_tag(pc, geo_len(t), TAG_BITS);
		end
		for (int t = NT - 1; t >= 1; t--)
			if (t_tag[t][idx[t]] == tg[t]) begin
				if (prov == 0) prov = t;
				else if (alt == 0) alt = t;
			end
		pred_bit = prov ? t_ctr[prov][idx[prov]][2] : bctr[1];
		alt_bit = alt ? t_ctr[alt][idx[alt]][2] : bctr[1];
		use_alt = prov != 0 && t_u[prov][idx[prov]] == 0 &&
			(t_ctr[prov][idx[prov]] == 3 || t_ctr[prov][idx[prov]] == 4) &&
			alt_bias >= ALT_MID;
		src = use_alt ? alt : prov;
		pctr = src ? t_ctr[src][idx[src]] : {1'b0, bctr};
		for (int k = 0; k < CT; k++) begin
			cidx[k] = (mix_tag(pc, geo_len(k + 1), CIW) ^ pctr) & (CD - 1);
			sum += 2 * (int'(sc[k][cidx[k]]) - int'(SC_MID)) + 1;
		end
		val = sum + (2 * (int'(pctr) - (src ? 4 : 2)) + 1) * CT;
		fin = val >= 0;
		mag = sum < 0 ? -sum : sum;
		v = '{pred: fin, prov: src[PROV_W-1:0], alt: use_alt};

		// base and tagged part
		if (tk && bctr != 3) bim[bidx] = bctr + 1;
		if (!tk && bctr != 0) bim[bidx] = bctr - 1;
		if (prov != 0 && pred_bit != alt_bit) begin
			if (t_u[prov][idx[prov]] == 0 &&
				(t_ctr[prov][idx[prov]] == 3 || t_ctr[prov][idx[prov]] == 4)) begin
				if (alt_bit == tk && alt_bias != ALT_MAX) alt_bias++;
				if (alt_bit != tk && alt_bias != 0) alt_bias--;
			end
			if (pred_bit == tk && t_u[prov][idx[prov]] != U_MAX) t_u[prov][idx[prov]]++;
			if (pred_bit != tk && t_u[prov][idx[prov]] != 0) t_u[prov][idx[prov]]--;
		end
		br_count++;
		if (br_count == clear_period) begin
			for (int t = 1; t < NT; t++)
				for (int i = 0; i < TD; i++) t_u[t][i][u_plane] = 1'b0;
			br_count = '0;
			u_plane = ~u_plane;
		end
		if (prov != 0) begin
			if (tk && t_ctr[prov][idx[prov]] != CTR_MAX) t_ctr[prov][idx[prov]]++;
			if (!tk && t_ctr[prov][idx[prov]] != 0) t_ctr[prov][idx[prov]]--;
		end
		// allocate on a TAGE miss
		if (pred_bit != tk && prov < NT - 1) begin
			for (int t = prov + 1; t < NT; t++)
				if (t_u[t][idx[t]] == 0) cand[nfree++] = t;
			if (nfree == 0) begin
				for (int t = prov + 1; t < NT; t++)
					if (t_u[t][idx[t]] != 0) t_u[t][idx[t]]--;
			end else begin
				for (int k = 0; k < nfree; k++) begin
					if (k + 1 < nfree && k < SKIP_W && skip[k]) continue;
					t_ctr[cand[k]][idx[cand[k]]] = CTR_NEW;
					t_tag[cand[k]][idx[cand[k]]] = tg[cand[k]];
					t_u[cand[k]][idx[cand[k]]] = '0;
					break;
				end
			end
		end

		// corrector and its threshold
		if (fin != tk || mag < sc_thr)
			for (int k = 0; k < CT; k++) begin
				if (tk && sc[k][cidx[k]] != SC_MAX) sc[k][cidx[k]]++;
				if (!tk && sc[k][cidx[k]] != 0) sc[k][cidx[k]]--;
			end
		if (fin != tk) begin
			if (thr_ctr != TC_MAX) thr_ctr++;
			if (thr_ctr == TC_MAX) begin
				if (sc_thr != THR_MAX) sc_thr++;
				thr_ctr = TC_MID;
			end
		end else if (mag < sc_thr) begin
			if (thr_ctr != 0) thr_ctr--;
			if (thr_ctr == 0) begin
				if (sc_thr != 0) sc_thr--;
				thr_ctr = TC_MID;
			end
		end
		ghist = {ghist[MAX_HIST-2:0], tk};
	endtask

	// watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin
		verdict_t got, want;
		if (!arst_n) begin
			clear_state();
			expected_q.delete();
			fail_count <= 0;
		end else begin
			if (cfg_write_en) clear_period = cfg_write_data;
			if (in_valid && !in_stall) begin
				predict_and_train(branch_pc, taken, alloc_skip, want);
				expected_q.push_back(want);
			end
			if (out_valid && !out_stall) begin
				got = '{pred: predicted_taken, prov: provider_table, alt: used_alternate};
				if (expected_q.size() == 0) begin
					$display("%t: result word with nothing expected: pred %0d prov %0d alt %0d",
						$time, got.pred, got.prov, got.alt);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						$display("%t: mismatch pred exp %0d got %0d, prov exp %0d got %0d, alt exp %0d got %0d",
							$time, want.pred, got.pred, want.prov, got.prov, want.alt, got.alt);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

>>> tb/tage_sc_branch_predictor_tb.sv
`timescale 1ns / 100ps

module tage_sc_branch_predictor_tb import tscbp_pkg::*;;

	logic                clk;
	logic                arst_n;
	logic                cfg_write_en;
	logic [PERIOD_W-1:0] cfg_write_data;
	logic                in_valid;
	logic                in_stall;
	logic [31:0]         branch_pc;
	logic                taken;
	logic [SKIP_W-1:0]   alloc_skip;
	logic                out_valid;
	logic                out_stall;
	logic                predicted_taken;
	logic [PROV_W-1:0]   provider_table;
	logic                used_alternate;
	int                  fail_count;
	int                  words_pending;

	int snd_idle_pct;
	int rcv_idle_pct;
	int hold_requests;

	// branch pool: each site follows one of four kinds of outcome pattern
	logic [31:0] site_pc [16];
	int          site_cnt [16];

	tage_sc_branch_predictor dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.branch_pc(branch_pc), .taken(taken), .alloc_skip(alloc_skip),
		.out_valid(out_valid), .out_stall(out_stall),
		.predicted_taken(predicted_taken), .provider_table(provider_table),
		.used_alternate(used_alternate)
	);

	tage_sc_branch_predictor_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.branch_pc(branch_pc), .taken(taken), .alloc_skip(alloc_skip),
		.out_valid(out_valid), .out_stall(out_stall),
		.predicted_taken(predicted_taken), .provider_table(provider_table),
		.used_alternate(used_alternate),
		.fail_count(fail_count), .words_pending(words_pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// receiver: random stalls, plus long hold-offs on request
	always @(posedge clk or negedge arst_n) begin
		int hold_left, hold_seen;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
			hold_seen = 0;
		end else if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = 300;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < rcv_idle_pct);
	end

	task automatic send_branch(input logic [31:0] pc, input logic tk,
		input logic [SKIP_W-1:0] skip);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		branch_pc <= pc;
		taken <= tk;
		alloc_skip <= skip;
		do @(posedge clk); while (in_stall);
	endtask

	// drain, let the block settle, then write the period
	task automatic write_period(input logic [PERIOD_W-1:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_pending != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_write_data <= v;
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	// mostly recurring sites with patterned outcomes, some noise
	task automatic send_random(int count);
		int s;
		logic tk;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < 80) begin
				s = $urandom_range(15);
				site_cnt[s]++;
				case (s % 4)
					0: tk = 1'b1;
					1: tk = 1'b0;
					2: tk = site_cnt[s][0];
					default: tk = (site_cnt[s] % (s + 3)) != 0;
				endcase
				if ($urandom_range(99) < 8) tk = ~tk;
				send_branch(site_pc[s], tk, SKIP_W'($urandom));
			end else
				send_branch($urandom, 1'($urandom), SKIP_W'($urandom));
		end
	endtask

	initial begin
		#5_000_000;
		$display("tage_sc_branch_predictor_tb: FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_write_data = '0;
		in_valid = 1'b0;
		branch_pc = '0;
		taken = 1'b0;
		alloc_skip = '0;
		snd_idle_pct = 17;
		rcv_idle_pct = 45;
		hold_requests = 0;
		foreach (site_pc[i]) begin
			site_pc[i] = $urandom;
			site_cnt[i] = 0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: smallest period clears after every branch
		write_period(21'd1);
		send_branch(32'h0, 1'b0, 6'h00);
		send_branch(32'hFFFF_FFFF, 1'b1, 6'h3F);
		send_branch(32'h0, 1'b1, 6'h2A);
		send_branch(32'hFFFF_FFFF, 1'b0, 6'h15);
		send_branch(32'h8000_0001, 1'b1, 6'h3F);
		write_period(21'd1048576);
		// repeated sites to build up matches, alternate use and allocation skips
		for (int i = 0; i < 16; i++)
			send_branch((i % 2) ? 32'h0000_07FF : 32'hFFFF_F800, i % 3 != 0,
				SKIP_W'(i * 4 + 3));

		// random, sender lightly idle, receiver heavily idle, long hold-off midway
		write_period(21'd37);
		send_random(300);
		hold_requests++;
		send_random(300);

		// zero period matches the count only when it wraps around
		write_period(21'd0);
		snd_idle_pct = 45;
		rcv_idle_pct = 17;
		send_random(600);

		write_period(21'd211);
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		send_random(630);

		in_valid <= 1'b0;
		@(posedge clk);
		while (words_pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("tage_sc_branch_predictor_tb: PASS");
		else
			$display("tage_sc_branch_predictor_tb: FAIL");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/tscbp_pkg.sv
rtl/core/tscbp_ram.sv
rtl/core/tscbp_ctrl.sv
rtl/core/tscbp_dp.sv
rtl/core/tage_sc_branch_predictor.sv
tb/tage_sc_branch_predictor_checker.sv
tb/tage_sc_branch_predictor_tb.sv
